// ----- hdl/track_table_with_aging_defines.svh -----
// assertion helpers for the track table checker
`ifndef TRACK_TABLE_WITH_AGING_DEFINES_SVH
`define TRACK_TABLE_WITH_AGING_DEFINES_SVH

// same-cycle implication
`define TTA_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("track table check failed");

// next-cycle implication
`define TTA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("track table check failed");

`endif

// ----- hdl/tta_pkg.sv -----
package tta_pkg;

   localparam int DEF_MAX_ENTRIES  = 16;
   localparam int DEF_TIME_BITS    = 32;
   localparam int DEF_PAYLOAD_BITS = 64;

   localparam int ID_W       = 64;
   localparam int TIME_W     = 32;
   localparam int PAY_W      = 64;
   localparam int COUNT_W    = 5;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] OP_UPDATE = 2'd0;
   localparam logic [1:0] OP_AGE    = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;
   localparam logic [1:0] OP_LIST   = 2'd3;

   localparam logic [1:0] REG_CAPACITY = 2'd0;
   localparam logic [1:0] REG_MISS     = 2'd1;
   localparam logic [1:0] REG_AGE      = 2'd2;

   localparam logic [4:0]  RST_CAPACITY  = 5'd16;
   localparam logic [7:0]  RST_MISS      = 8'd3;
   localparam logic [31:0] RST_AGE_LIMIT = 32'd30000;

   typedef struct packed {
      logic [1:0]        op;
      logic [ID_W-1:0]   track_key;
      logic [TIME_W-1:0] now_time;
      logic [PAY_W-1:0]  track_payload;
   } tta_req_type;

   typedef struct packed {
      logic               found;
      logic [ID_W-1:0]    result_id;
      logic [PAY_W-1:0]   result_payload;
      logic               evicted;
      logic [ID_W-1:0]    evicted_id;
      logic [COUNT_W-1:0] entry_total;
      logic               last;
   } tta_rsp_type;

   typedef enum logic [2:0] {
      PROC_NONE,
      PROC_UPD,
      PROC_AGE,
      PROC_LOOK,
      PROC_CNT
   } tta_proc_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT,
      ST_CSCAN,
      ST_CDRAIN,
      ST_LSTART,
      ST_LRD,
      ST_LCHK,
      ST_EMIT
   } tta_state_type;

   typedef struct packed {
      logic         ready;
      logic         accept;
      logic         cnt_clr;
      logic         step;
      tta_proc_type proc;
      logic         commit;
      logic         out_load;
      logic         out_list;
   } tta_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       scan_last;
      logic       out_free;
      logic       total_zero;
      logic       list_active;
      logic       list_end;
   } tta_stat_type;

endpackage

// ----- hdl/tta_csr.sv -----
module tta_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tta_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tta_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tta_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output logic [4:0]                      capacity_limit,
   output logic [7:0]                      miss_limit,
   output logic [31:0]                     age_limit
);
   import tta_pkg::*;

   logic [4:0]  capacity_ff, capacity_in;
   logic [7:0]  miss_ff, miss_in;
   logic [31:0] age_ff, age_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign reg_idx = csr_paddr[3:2];
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      capacity_in = capacity_ff;
      miss_in     = miss_ff;
      age_in      = age_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_CAPACITY: capacity_in = csr_pwdata[4:0];
            REG_MISS:     miss_in     = csr_pwdata[7:0];
            REG_AGE:      age_in      = csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_CAPACITY: csr_prdata = {27'd0, capacity_ff};
         REG_MISS:     csr_prdata = {24'd0, miss_ff};
         REG_AGE:      csr_prdata = age_ff;
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= RST_CAPACITY;
         miss_ff     <= RST_MISS;
         age_ff      <= RST_AGE_LIMIT;
      end else begin
         capacity_ff <= capacity_in;
         miss_ff     <= miss_in;
         age_ff      <= age_in;
      end
   end

   assign capacity_limit = capacity_ff;
   assign miss_limit     = miss_ff;
   assign age_limit      = age_ff;

endmodule

// ----- hdl/tta_ctrl.sv -----
module tta_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  tta_pkg::tta_stat_type stat,
   output tta_pkg::tta_cmd_type  cmd
);
   import tta_pkg::*;

   tta_state_type state_ff, state_in;
   tta_proc_type  work_proc;

   always_comb begin
      case (stat.op)
         OP_UPDATE: work_proc = PROC_UPD;
         OP_AGE:    work_proc = PROC_AGE;
         OP_LOOKUP: work_proc = PROC_LOOK;
         default:   work_proc = PROC_NONE;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_START;
         ST_START:  state_in = (stat.op == OP_LIST) ? ST_CSCAN : ST_SCAN;
         ST_SCAN:   if (stat.scan_last) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = (stat.op == OP_UPDATE) ? ST_COMMIT : ST_CSCAN;
         ST_COMMIT: state_in = ST_CSCAN;
         ST_CSCAN:  if (stat.scan_last) state_in = ST_CDRAIN;
         ST_CDRAIN: state_in = (stat.op == OP_LIST) ? ST_LSTART : ST_EMIT;
         ST_LSTART: state_in = stat.total_zero ? ST_EMIT : ST_LRD;
         ST_LRD:    state_in = ST_LCHK;
         ST_LCHK: begin
            if (!stat.list_active || stat.out_free) begin
               state_in = stat.list_end ? ST_IDLE : ST_LRD;
            end
         end
         ST_EMIT:   if (stat.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.proc = PROC_NONE;
      case (state_ff)
         ST_IDLE: begin
            cmd.ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            cmd.proc = work_proc;
         end
         ST_DRAIN: begin
            cmd.proc    = work_proc;
            cmd.cnt_clr = 1'b1;
         end
         ST_COMMIT: cmd.commit = 1'b1;
         ST_CSCAN: begin
            cmd.step = 1'b1;
            cmd.proc = PROC_CNT;
         end
         ST_CDRAIN: begin
            cmd.proc    = PROC_CNT;
            cmd.cnt_clr = 1'b1;
         end
         ST_LRD: cmd.step = 1'b1;
         ST_LCHK: begin
            cmd.out_load = stat.list_active && stat.out_free;
            cmd.out_list = 1'b1;
         end
         ST_EMIT: cmd.out_load = stat.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/tta_datapath.sv -----
module tta_datapath #(
   parameter int MAX_ENTRIES  = tta_pkg::DEF_MAX_ENTRIES,
   parameter int TIME_BITS    = tta_pkg::DEF_TIME_BITS,
   parameter int PAYLOAD_BITS = tta_pkg::DEF_PAYLOAD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tta_pkg::tta_req_type  req_word,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output tta_pkg::tta_rsp_type  rsp_word,
   input  logic [4:0]            capacity_limit,
   input  logic [7:0]            miss_limit,
   input  logic [31:0]           age_limit,
   input  tta_pkg::tta_cmd_type  cmd,
   output tta_pkg::tta_stat_type stat
);
   import tta_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int AGE_W = (TIME_BITS > 32) ? TIME_BITS : 32;
   localparam int CMP_W = (CNT_W > 5) ? CNT_W + 1 : 6;

   // slot storage
   logic [ID_W-1:0]         key_mem  [MAX_ENTRIES];
   logic [PAYLOAD_BITS-1:0] data_mem [MAX_ENTRIES];
   logic [TIME_BITS-1:0]    time_mem [MAX_ENTRIES];
   logic [7:0]              miss_mem [MAX_ENTRIES];

   logic                    wr_en, wr_all;
   logic [IDX_W-1:0]        wr_slot;
   logic [7:0]              wr_miss;

   logic [1:0]              op_ff, op_in;
   logic [ID_W-1:0]         id_ff, id_in;
   logic [TIME_BITS-1:0]    now_ff, now_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic [IDX_W-1:0]        cnt_ff, cnt_in;
   logic                    rd_vld_ff;
   logic [IDX_W-1:0]        rd_slot_ff;
   logic [ID_W-1:0]         rd_key_ff;
   logic [PAYLOAD_BITS-1:0] rd_data_ff;
   logic [TIME_BITS-1:0]    rd_time_ff;
   logic [7:0]              rd_miss_ff;
   logic [MAX_ENTRIES-1:0]  valid_ff, valid_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic                    hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]        hit_slot_ff, hit_slot_in;
   logic [PAYLOAD_BITS-1:0] hit_data_ff, hit_data_in;
   logic                    free_found_ff, free_found_in;
   logic [IDX_W-1:0]        free_slot_ff, free_slot_in;
   logic                    old_found_ff, old_found_in;
   logic [IDX_W-1:0]        old_slot_ff, old_slot_in;
   logic [TIME_BITS-1:0]    old_time_ff, old_time_in;
   logic [ID_W-1:0]         old_key_ff, old_key_in;
   logic [CNT_W-1:0]        total_ff, total_in;
   logic [CNT_W-1:0]        list_n_ff, list_n_in;
   logic                    ev_ff, ev_in;
   logic [ID_W-1:0]         evid_ff, evid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tta_rsp_type             rsp_word_ff, rsp_word_in;

   logic                    rd_valid, rd_active;
   logic [7:0]              miss_inc;
   logic [TIME_BITS-1:0]    age_v;
   logic [CMP_W-1:0]        cap_v;
   logic                    do_evict;
   logic [IDX_W-1:0]        ins_slot;
   tta_rsp_type             out_v;

   assign rd_valid  = valid_ff[rd_slot_ff];
   assign rd_active = rd_valid && (rd_miss_ff < miss_limit);
   assign miss_inc  = (rd_miss_ff == 8'hFF) ? rd_miss_ff : rd_miss_ff + 8'd1;
   // negative age counts as zero
   assign age_v     = (now_ff >= rd_time_ff) ? now_ff - rd_time_ff : '0;

   always_comb begin
      if (capacity_limit == 5'd0) begin
         cap_v = CMP_W'(1);
      end else if (CMP_W'(capacity_limit) > CMP_W'(MAX_ENTRIES)) begin
         cap_v = CMP_W'(MAX_ENTRIES);
      end else begin
         cap_v = CMP_W'(capacity_limit);
      end
   end

   assign do_evict = (CMP_W'(fill_ff) >= cap_v) && (fill_ff != '0);
   assign ins_slot = (do_evict && (!free_found_ff || old_slot_ff < free_slot_ff)) ?
                     old_slot_ff : free_slot_ff;

   always_comb begin
      op_in         = op_ff;
      id_in         = id_ff;
      now_in        = now_ff;
      pay_in        = pay_ff;
      cnt_in        = cnt_ff;
      valid_in      = valid_ff;
      fill_in       = fill_ff;
      hit_found_in  = hit_found_ff;
      hit_slot_in   = hit_slot_ff;
      hit_data_in   = hit_data_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      old_found_in  = old_found_ff;
      old_slot_in   = old_slot_ff;
      old_time_in   = old_time_ff;
      old_key_in    = old_key_ff;
      total_in      = total_ff;
      list_n_in     = list_n_ff;
      ev_in         = ev_ff;
      evid_in       = evid_ff;
      wr_en         = 1'b0;
      wr_all        = 1'b0;
      wr_slot       = rd_slot_ff;
      wr_miss       = miss_inc;

      if (cmd.accept) begin
         op_in         = req_word.op;
         id_in         = req_word.track_key;
         now_in        = TIME_BITS'(req_word.now_time);
         pay_in        = PAYLOAD_BITS'(req_word.track_payload);
         cnt_in        = '0;
         fill_in       = '0;
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
         old_found_in  = 1'b0;
         total_in      = '0;
         list_n_in     = '0;
         ev_in         = 1'b0;
         evid_in       = '0;
      end
      if (cmd.cnt_clr) cnt_in = '0;
      if (cmd.step)    cnt_in = cnt_ff + IDX_W'(1);

      if (rd_vld_ff) begin
         case (cmd.proc)
            PROC_UPD, PROC_LOOK: begin
               if (rd_valid) begin
                  fill_in = fill_ff + CNT_W'(1);
                  if (!hit_found_ff && rd_key_ff == id_ff) begin
                     hit_found_in = 1'b1;
                     hit_slot_in  = rd_slot_ff;
                     hit_data_in  = rd_data_ff;
                  end
                  // oldest time wins, smaller key on a tie
                  if (!old_found_ff || rd_time_ff < old_time_ff ||
                      (rd_time_ff == old_time_ff && rd_key_ff < old_key_ff)) begin
                     old_found_in = 1'b1;
                     old_slot_in  = rd_slot_ff;
                     old_time_in  = rd_time_ff;
                     old_key_in   = rd_key_ff;
                  end
               end else if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in  = rd_slot_ff;
               end
            end
            PROC_AGE: begin
               if (rd_valid) begin
                  wr_en = 1'b1;
                  if (miss_inc >= miss_limit || AGE_W'(age_v) >= AGE_W'(age_limit)) begin
                     valid_in[rd_slot_ff] = 1'b0;
                  end
               end
            end
            PROC_CNT: begin
               if (rd_active) total_in = total_ff + CNT_W'(1);
            end
            default: ;
         endcase
      end

      if (cmd.commit) begin
         if (hit_found_ff) begin
            wr_en   = 1'b1;
            wr_all  = 1'b1;
            wr_slot = hit_slot_ff;
            wr_miss = 8'd0;
         end else begin
            if (do_evict) begin
               valid_in[old_slot_ff] = 1'b0;
               ev_in   = 1'b1;
               evid_in = old_key_ff;
            end
            if (do_evict || free_found_ff) begin
               wr_en   = 1'b1;
               wr_all  = 1'b1;
               wr_slot = ins_slot;
               wr_miss = 8'd0;
               valid_in[ins_slot] = 1'b1;
            end
         end
      end

      if (cmd.out_load && cmd.out_list) list_n_in = list_n_ff + CNT_W'(1);
   end

   always_comb begin
      out_v = '0;
      out_v.entry_total = COUNT_W'(total_ff);
      out_v.last = 1'b1;
      case (op_ff)
         OP_UPDATE: begin
            out_v.found          = hit_found_ff;
            out_v.result_id      = id_ff;
            out_v.result_payload = PAY_W'(pay_ff);
            out_v.evicted        = ev_ff;
            out_v.evicted_id     = evid_ff;
         end
         OP_LOOKUP: begin
            out_v.found          = hit_found_ff;
            out_v.result_id      = id_ff;
            out_v.result_payload = hit_found_ff ? PAY_W'(hit_data_ff) : '0;
         end
         OP_LIST: begin
            if (cmd.out_list) begin
               out_v.found          = 1'b1;
               out_v.result_id      = rd_key_ff;
               out_v.result_payload = PAY_W'(rd_data_ff);
               out_v.last           = ((list_n_ff + CNT_W'(1)) == total_ff);
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = out_v;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (wr_all) begin
            key_mem[wr_slot]  <= id_ff;
            data_mem[wr_slot] <= pay_ff;
            time_mem[wr_slot] <= now_ff;
         end
         miss_mem[wr_slot] <= wr_miss;
      end
      if (cmd.step) begin
         rd_key_ff  <= key_mem[cnt_ff];
         rd_data_ff <= data_mem[cnt_ff];
         rd_time_ff <= time_mem[cnt_ff];
         rd_miss_ff <= miss_mem[cnt_ff];
         rd_slot_ff <= cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= cmd.step;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      now_ff        <= now_in;
      pay_ff        <= pay_in;
      fill_ff       <= fill_in;
      hit_found_ff  <= hit_found_in;
      hit_slot_ff   <= hit_slot_in;
      hit_data_ff   <= hit_data_in;
      free_found_ff <= free_found_in;
      free_slot_ff  <= free_slot_in;
      old_found_ff  <= old_found_in;
      old_slot_ff   <= old_slot_in;
      old_time_ff   <= old_time_in;
      old_key_ff    <= old_key_in;
      total_ff      <= total_in;
      list_n_ff     <= list_n_in;
      ev_ff         <= ev_in;
      evid_ff       <= evid_in;
      rsp_word_ff   <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign stat.op          = op_ff;
   assign stat.scan_last   = (cnt_ff == IDX_W'(MAX_ENTRIES - 1));
   assign stat.out_free    = !rsp_valid_ff || !rsp_stall;
   assign stat.total_zero  = (total_ff == '0);
   assign stat.list_active = rd_active;
   assign stat.list_end    = (rd_slot_ff == IDX_W'(MAX_ENTRIES - 1));

endmodule

// ----- hdl/track_table_with_aging.sv -----
// Keyed track table with oldest-entry eviction and aging.
// req channel: one word per operation (update/insert, aging tick, lookup,
// list); req_stall stays high from the accepting edge until the controller is
// back in idle, after the last result word has gone to the output register.
// rsp channel: one word per update, aging tick or lookup; a list gives one
// word per active entry in slot order (or a single empty word), with last set
// on the final word.
// Every operation walks the slot memory one slot per cycle: a work pass
// (skipped for list) and a pass that counts the active entries. Aging and
// lookup load their word after the count pass; update first passes a commit
// state that writes the slot. A list then walks the slots once more, reading
// and checking one slot at a time and loading a word for each active entry;
// an empty list loads its single word straight after the count pass.
// A stalled rsp word holds in the output register; the list pass waits on it
// before loading the next entry, and a new request can be accepted once the
// controller is back in idle, even if the last word is still stalled.
// Reset empties the table and restores the registers (capacity 16, miss
// limit 3, age limit 30000); no clearing pass is needed.
// Registers: capacity_limit at 0x0, miss_limit at 0x4, age_limit at 0x8.
module track_table_with_aging #(
   parameter int MAX_ENTRIES  = tta_pkg::DEF_MAX_ENTRIES,
   parameter int TIME_BITS    = tta_pkg::DEF_TIME_BITS,
   parameter int PAYLOAD_BITS = tta_pkg::DEF_PAYLOAD_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tta_pkg::tta_req_type            req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tta_pkg::tta_rsp_type            rsp_word,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tta_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tta_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tta_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import tta_pkg::*;

   tta_cmd_type  cmd;
   tta_stat_type stat;
   logic [4:0]   capacity_limit;
   logic [7:0]   miss_limit;
   logic [31:0]  age_limit;

   tta_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .capacity_limit (capacity_limit),
      .miss_limit     (miss_limit),
      .age_limit      (age_limit)
   );

   tta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   tta_datapath #(
      .MAX_ENTRIES  (MAX_ENTRIES),
      .TIME_BITS    (TIME_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_word       (req_word),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_word       (rsp_word),
      .capacity_limit (capacity_limit),
      .miss_limit     (miss_limit),
      .age_limit      (age_limit),
      .cmd            (cmd),
      .stat           (stat)
   );

   assign req_stall = !cmd.ready;

endmodule

// ----- hdl/tta_checker.sv -----
`include "track_table_with_aging_defines.svh"

module tta_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input tta_pkg::tta_rsp_type rsp_word
);
   import tta_pkg::*;

   logic rsp_held;
   logic evict_ok;
   logic more_ok;

   assign rsp_held = rsp_valid && rsp_stall;
   assign evict_ok = !rsp_word.found && rsp_word.last;
   assign more_ok  = rsp_word.found && !rsp_word.evicted && (rsp_word.evicted_id == '0);

   `TTA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_word))
   `TTA_ASSERT_IMPL(a_evict_word, clock, reset, rsp_valid && rsp_word.evicted, evict_ok)
   `TTA_ASSERT_IMPL(a_list_more, clock, reset, rsp_valid && !rsp_word.last, more_ok)
   `TTA_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

endmodule

bind track_table_with_aging tta_checker u_tta_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
